// File: hw/rtl/bmhq_pkg.sv
// shared types and constants for the binary min-heap queue
`default_nettype none

package bmhq_pkg;

    localparam int KEY_W         = 64;
    localparam int PAYLOAD_W     = 16;
    localparam int COUNT_W       = 7;
    localparam int OP_W          = 2;
    localparam int STATUS_W      = 2;
    localparam int DEPTH_DEF     = 64;
    localparam int TAG_WIDTH_DEF = 16;

    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
    localparam logic [OP_W-1:0] OP_PEEK   = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0]         op;
        logic signed [KEY_W-1:0] key;
        logic [PAYLOAD_W-1:0]    payload;
    } t_req;

    typedef struct packed {
        logic signed [KEY_W-1:0] out_key;
        logic [PAYLOAD_W-1:0]    out_payload;
        logic [STATUS_W-1:0]     status;
        logic [COUNT_W-1:0]      entry_count;
    } t_rsp;

endpackage

`default_nettype wire

// File: hw/rtl/bmhq_ram.sv
// generic single-write single-read ram with registered read data
`default_nettype none

module bmhq_ram #(
    parameter int WIDTH = 80,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]              o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: hw/rtl/binary_min_heap_queue_core.sv
// binary min-heap priority queue: sequencer, shared key comparator and heap ram
// insert: the new key climbs from the next free slot toward the root, at most log2(DEPTH) levels
// delete: the root is returned, the last entry moves to the root and sinks while a child key is smaller
// peek returns the root; a full insert or an empty delete or peek gets a reject status
// one request at a time: the single ram read port and the comparator set the pace
// sync active-low reset empties the heap; ram contents are not cleared
`default_nettype none

module binary_min_heap_queue_core
    import bmhq_pkg::*;
#(
    parameter int DEPTH     = DEPTH_DEF,
    parameter int TAG_WIDTH = TAG_WIDTH_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_req_valid,
    output logic      o_req_ready,
    input  wire t_req i_req,
    output logic      o_rsp_valid,
    input  wire logic i_rsp_ready,
    output t_rsp      o_rsp
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = AW + 2;
    localparam int DW = KEY_W + TAG_WIDTH;

    typedef enum logic [3:0] {
        S_IDLE,
        S_START,
        S_UP,
        S_UP_FIN,
        S_ROOT,
        S_LAST,
        S_DN_RD,
        S_DN_L,
        S_DN_R,
        S_DN_CMP,
        S_RESP
    } t_state;

    t_state                  r_state, n_state;
    logic [OP_W-1:0]         r_op, n_op;
    logic signed [KEY_W-1:0] r_key, n_key;
    logic [TAG_WIDTH-1:0]    r_tag, n_tag;
    logic [CW-1:0]           r_count, n_count;
    logic [AW-1:0]           r_pos, n_pos;
    logic signed [KEY_W-1:0] r_ckey, n_ckey;
    logic [TAG_WIDTH-1:0]    r_ctag, n_ctag;
    logic [AW-1:0]           r_cidx, n_cidx;
    t_rsp                    r_rsp, n_rsp;

    logic                    mem_we;
    logic [AW-1:0]           mem_waddr;
    logic [DW-1:0]           mem_wdata;
    logic [AW-1:0]           mem_raddr;
    logic [DW-1:0]           rd_data;
    logic signed [KEY_W-1:0] rd_key;
    logic [TAG_WIDTH-1:0]    rd_tag;

    logic signed [KEY_W-1:0] cmp_a, cmp_b;
    logic                    cmp_lt;

    logic [31:0]             w_in_tag32;
    logic [31:0]             w_rd_tag32;
    logic [IW-1:0]           w_left, w_right, w_cnt, w_cleft;
    logic [AW-1:0]           w_par, w_cpar;

    bmhq_ram #(
        .WIDTH (DW),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (rd_data)
    );

    assign rd_key     = rd_data[DW-1 -: KEY_W];
    assign rd_tag     = rd_data[TAG_WIDTH-1:0];
    assign w_in_tag32 = 32'(i_req.payload);
    assign w_rd_tag32 = 32'(rd_tag);

    // the one key comparator, shared by sift up and sift down
    assign cmp_lt = cmp_a < cmp_b;

    assign w_left  = {1'b0, r_pos, 1'b1};
    assign w_right = w_left + IW'(1);
    assign w_cleft = {1'b0, r_cidx, 1'b1};
    assign w_cnt   = IW'(r_count);
    assign w_par   = AW'((r_pos - AW'(1)) >> 1);
    assign w_cpar  = AW'((r_count - CW'(1)) >> 1);

    assign o_req_ready = (r_state == S_IDLE);
    assign o_rsp_valid = (r_state == S_RESP);

    always_comb begin
        o_rsp             = r_rsp;
        o_rsp.entry_count = COUNT_W'(r_count);
    end

    always_comb begin
        n_state   = r_state;
        n_op      = r_op;
        n_key     = r_key;
        n_tag     = r_tag;
        n_count   = r_count;
        n_pos     = r_pos;
        n_ckey    = r_ckey;
        n_ctag    = r_ctag;
        n_cidx    = r_cidx;
        n_rsp     = r_rsp;
        mem_we    = 1'b0;
        mem_waddr = r_pos;
        mem_wdata = {r_key, r_tag};
        mem_raddr = '0;
        cmp_a     = rd_key;
        cmp_b     = r_key;

        unique case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    n_op    = i_req.op;
                    n_key   = i_req.key;
                    n_tag   = w_in_tag32[TAG_WIDTH-1:0];
                    n_state = S_START;
                end
            end
            S_START: begin
                n_rsp = '0;
                case (r_op) inside
                    OP_INSERT: begin
                        if (r_count == CW'(DEPTH)) begin
                            n_rsp.status = STATUS_FULL;
                            n_state      = S_RESP;
                        end else if (r_count == '0) begin
                            mem_we    = 1'b1;
                            mem_waddr = '0;
                            n_count   = CW'(1);
                            n_state   = S_RESP;
                        end else begin
                            n_pos     = AW'(r_count);
                            mem_raddr = w_cpar;
                            n_state   = S_UP;
                        end
                    end
                    OP_DELETE, OP_PEEK: begin
                        if (r_count == '0) begin
                            n_rsp.status = STATUS_EMPTY;
                            n_state      = S_RESP;
                        end else begin
                            mem_raddr = '0;
                            n_state   = S_ROOT;
                        end
                    end
                    default: begin
                        n_state = S_RESP;
                    end
                endcase
            end
            S_UP: begin
                // read data holds the parent of the hole
                if (cmp_lt) begin
                    mem_we  = 1'b1;
                    n_count = r_count + CW'(1);
                    n_state = S_RESP;
                end else begin
                    mem_we    = 1'b1;
                    mem_wdata = rd_data;
                    n_pos     = w_par;
                    if (w_par == '0) begin
                        n_state = S_UP_FIN;
                    end else begin
                        mem_raddr = AW'((w_par - AW'(1)) >> 1);
                    end
                end
            end
            S_UP_FIN: begin
                mem_we    = 1'b1;
                mem_waddr = '0;
                n_count   = r_count + CW'(1);
                n_state   = S_RESP;
            end
            S_ROOT: begin
                n_rsp.out_key     = rd_key;
                n_rsp.out_payload = w_rd_tag32[PAYLOAD_W-1:0];
                if (r_op == OP_PEEK) begin
                    n_state = S_RESP;
                end else begin
                    n_count = r_count - CW'(1);
                    if (r_count == CW'(1)) begin
                        n_state = S_RESP;
                    end else begin
                        mem_raddr = AW'(r_count - CW'(1));
                        n_state   = S_LAST;
                    end
                end
            end
            S_LAST: begin
                // last entry becomes the one sinking from the root
                n_key   = rd_key;
                n_tag   = rd_tag;
                n_pos   = '0;
                n_state = S_DN_RD;
            end
            S_DN_RD: begin
                if (w_left >= w_cnt) begin
                    mem_we  = 1'b1;
                    n_state = S_RESP;
                end else begin
                    mem_raddr = w_left[AW-1:0];
                    n_state   = S_DN_L;
                end
            end
            S_DN_L: begin
                n_ckey = rd_key;
                n_ctag = rd_tag;
                n_cidx = w_left[AW-1:0];
                if (w_right < w_cnt) begin
                    mem_raddr = w_right[AW-1:0];
                    n_state   = S_DN_R;
                end else begin
                    n_state = S_DN_CMP;
                end
            end
            S_DN_R: begin
                // children tie: the right one wins
                cmp_a = r_ckey;
                cmp_b = rd_key;
                if (!cmp_lt) begin
                    n_ckey = rd_key;
                    n_ctag = rd_tag;
                    n_cidx = w_right[AW-1:0];
                end
                n_state = S_DN_CMP;
            end
            S_DN_CMP: begin
                cmp_a = r_ckey;
                cmp_b = r_key;
                mem_we = 1'b1;
                if (cmp_lt) begin
                    mem_wdata = {r_ckey, r_ctag};
                    n_pos     = r_cidx;
                    if (w_cleft < w_cnt) begin
                        mem_raddr = w_cleft[AW-1:0];
                        n_state   = S_DN_L;
                    end else begin
                        n_state = S_DN_RD;
                    end
                end else begin
                    n_state = S_RESP;
                end
            end
            S_RESP: begin
                if (i_rsp_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
        r_op   <= n_op;
        r_key  <= n_key;
        r_tag  <= n_tag;
        r_pos  <= n_pos;
        r_ckey <= n_ckey;
        r_ctag <= n_ctag;
        r_cidx <= n_cidx;
        r_rsp  <= n_rsp;
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("entry count above depth");

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_req_ready |-> !o_rsp_valid)
        else $error("request taken while a response is pending");

    a_full_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp_valid && o_rsp.status == STATUS_FULL) |-> r_count == CW'(DEPTH))
        else $error("full status with free room");

    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp_valid && o_rsp.status == STATUS_EMPTY) |-> r_count == '0)
        else $error("empty status on a non-empty heap");

    a_write_in_heap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> IW'(mem_waddr) <= IW'(r_count))
        else $error("heap write beyond the live entries");

endmodule

`default_nettype wire
